/* rtl/core/ceq_pkg.sv */
`timescale 1ns / 1ps

package ceq_pkg;

	localparam int DEPTH     = 16;
	localparam int CODE_BITS = 16;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int CFG_BITS  = 5;

	typedef logic [CODE_BITS-1:0] code_t;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POLL = 2'd1,
		ACT_DIAG = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] error_code;
	} in_t;

	typedef struct packed {
		logic        poll_valid;
		logic [15:0] record_code;
		logic [31:0] record_sequence;
		logic [31:0] record_repeats;
		logic [4:0]  occupancy;
		logic [31:0] produced_total;
		logic [31:0] coalesced_total;
		logic [31:0] dropped_total;
		logic [31:0] diagnostic_failures;
		logic        first_valid;
		logic [15:0] first_code;
	} out_t;

	// one queued record
	typedef struct packed {
		code_t       code;
		logic [31:0] sequence_num;
		logic [31:0] repeats;
	} rec_t;

	// per-cell controls from the queue controller
	typedef struct packed {
		logic occ;    // cell holds a live record
		logic shift;  // take neighbor's record (pop)
		logic load;   // take the new record (append)
		logic bump;   // repeat count up (coalesce)
	} cell_ctrl_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

/* rtl/core/ceq_cell.sv */
`timescale 1ns / 1ps

module ceq_cell (
	input  logic               clk,
	input  ceq_pkg::cell_ctrl_t ctrl,
	input  ceq_pkg::rec_t      nxt_rec,
	input  ceq_pkg::rec_t      new_rec,
	input  ceq_pkg::code_t     cmp_code,
	output ceq_pkg::rec_t      rec,
	output logic               match
);

	ceq_pkg::rec_t rec_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			rec_q <= nxt_rec;
		end else if (ctrl.load) begin
			rec_q <= new_rec;
		end else if (ctrl.bump) begin
			rec_q.repeats <= ceq_pkg::sat_inc(rec_q.repeats);
		end
	end

	assign match = ctrl.occ && (rec_q.code == cmp_code);
	assign rec   = rec_q;

endmodule

/* rtl/core/coalescing_error_queue_top.sv */
`timescale 1ns / 1ps

// Coalescing error queue. Records sit in order in a row of cells, oldest in
// cell 0; a poll shifts the whole row down by one, a new record is loaded into
// the first free cell, and a push whose code matches a queued record bumps
// that record's repeat count (all cells compare in parallel). A word is first
// registered at the input, then compared against every cell while the row,
// counters and output register are updated. in_ready is low while a word is
// in process, and longer if the previous result word is still not taken.
// A cfg_we write sets the capacity (clamped to 1..16) and empties the queue.

module coalescing_error_queue_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  ceq_pkg::in_t            in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output ceq_pkg::out_t           out_data,
	input  logic                    cfg_we,
	input  logic [ceq_pkg::CFG_BITS-1:0] cfg_wdata
);

	localparam int D  = ceq_pkg::DEPTH;
	localparam int CB = ceq_pkg::CNT_BITS;

	ceq_pkg::in_t       item_s1;
	logic               busy_q;
	logic [CB-1:0]      cap_q;
	logic [CB-1:0]      count_q;
	logic [31:0]        seq_q;
	logic [31:0]        prod_q;
	logic [31:0]        coal_q;
	logic [31:0]        drop_q;
	logic [31:0]        diag_q;
	logic               first_seen_q;
	ceq_pkg::code_t     first_code_q;
	ceq_pkg::out_t      out_q;
	logic               out_valid_q;

	ceq_pkg::cell_ctrl_t cell_ctrl [D];
	ceq_pkg::rec_t       cell_rec  [D];
	logic [D-1:0]        match;

	ceq_pkg::code_t  code;
	ceq_pkg::rec_t   new_rec;
	logic            accept;
	logic            done;
	logic            is_push;
	logic            is_poll;
	logic            is_diag;
	logic            any_match;
	logic            full;
	logic            do_append;
	logic            do_pop;
	logic [CB-1:0]   count_d;
	logic [31:0]     prod_d;
	logic [31:0]     coal_d;
	logic [31:0]     drop_d;
	logic [31:0]     diag_d;
	logic [31:0]     seq_d;
	logic            first_seen_d;
	ceq_pkg::code_t  first_code_d;
	ceq_pkg::out_t   out_d;
	logic [CB-1:0]   cap_clamped;

	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	assign done      = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign code    = item_s1.error_code[ceq_pkg::CODE_BITS-1:0];
	assign is_push = (item_s1.action == ceq_pkg::ACT_PUSH);
	assign is_poll = (item_s1.action == ceq_pkg::ACT_POLL);
	assign is_diag = (item_s1.action == ceq_pkg::ACT_DIAG);

	// codes in the row are unique, so at most one cell matches
	assign any_match = |match;
	assign full      = (count_q >= cap_q);
	assign do_append = done && is_push && !any_match && !full;
	assign do_pop    = done && is_poll && (count_q != '0);

	assign new_rec.code         = code;
	assign new_rec.sequence_num = seq_q;
	assign new_rec.repeats      = 32'd1;

	genvar gi;
	generate
		for (gi = 0; gi < D; gi++) begin : g_cell
			always_comb begin
				cell_ctrl[gi].occ   = (CB'(gi) < count_q);
				cell_ctrl[gi].shift = do_pop;
				cell_ctrl[gi].load  = do_append && (count_q == CB'(gi));
				cell_ctrl[gi].bump  = done && is_push && match[gi];
			end

			if (gi == D - 1) begin : g_last
				ceq_cell u_cell (
					.clk      (clk),
					.ctrl     (cell_ctrl[gi]),
					.nxt_rec  ('0),
					.new_rec  (new_rec),
					.cmp_code (code),
					.rec      (cell_rec[gi]),
					.match    (match[gi])
				);
			end else begin : g_mid
				ceq_cell u_cell (
					.clk      (clk),
					.ctrl     (cell_ctrl[gi]),
					.nxt_rec  (cell_rec[gi+1]),
					.new_rec  (new_rec),
					.cmp_code (code),
					.rec      (cell_rec[gi]),
					.match    (match[gi])
				);
			end
		end
	endgenerate

	always_comb begin
		count_d      = count_q;
		prod_d       = prod_q;
		coal_d       = coal_q;
		drop_d       = drop_q;
		diag_d       = diag_q;
		seq_d        = seq_q;
		first_seen_d = first_seen_q;
		first_code_d = first_code_q;
		if (is_push) begin
			prod_d = ceq_pkg::sat_inc(prod_q);
			seq_d  = ceq_pkg::sat_inc(seq_q);
			if (!first_seen_q) begin
				first_seen_d = 1'b1;
				first_code_d = code;
			end
			if (any_match) begin
				coal_d = ceq_pkg::sat_inc(coal_q);
			end else if (full) begin
				drop_d = ceq_pkg::sat_inc(drop_q);
			end else begin
				count_d = count_q + CB'(1);
			end
		end else if (is_poll) begin
			if (count_q != '0) begin
				count_d = count_q - CB'(1);
			end
		end else if (is_diag) begin
			diag_d = ceq_pkg::sat_inc(diag_q);
		end

		out_d                     = '0;
		if (is_poll && (count_q != '0)) begin
			out_d.poll_valid      = 1'b1;
			out_d.record_code     = 16'(cell_rec[0].code);
			out_d.record_sequence = cell_rec[0].sequence_num;
			out_d.record_repeats  = cell_rec[0].repeats;
		end
		out_d.occupancy           = 5'(count_d);
		out_d.produced_total      = prod_d;
		out_d.coalesced_total     = coal_d;
		out_d.dropped_total       = drop_d;
		out_d.diagnostic_failures = diag_d;
		out_d.first_valid         = first_seen_d;
		out_d.first_code          = 16'(first_code_d);
	end

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_clamped = CB'(1);
		end else if (32'(cfg_wdata) > 32'(D)) begin
			cap_clamped = CB'(D);
		end else begin
			cap_clamped = CB'(cfg_wdata);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (done) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cap_q        <= CB'(D);
			count_q      <= '0;
			seq_q        <= '0;
			prod_q       <= '0;
			coal_q       <= '0;
			drop_q       <= '0;
			diag_q       <= '0;
			first_seen_q <= 1'b0;
			first_code_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				cap_q   <= cap_clamped;
				count_q <= '0;
			end else if (done) begin
				count_q <= count_d;
			end

			if (done) begin
				seq_q        <= seq_d;
				prod_q       <= prod_d;
				coal_q       <= coal_d;
				drop_q       <= drop_d;
				diag_q       <= diag_d;
				first_seen_q <= first_seen_d;
				first_code_q <= first_code_d;
			end
		end
	end

endmodule

/* verif/tb_coalescing_error_queue_top.sv */
`timescale 1ns / 1ps

module tb_coalescing_error_queue_top;

	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	localparam int MODE_STEADY     = 0;
	localparam int MODE_SRC_IDLE   = 1;
	localparam int MODE_SINK_STALL = 2;
	localparam int MODE_BOTH       = 3;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	ceq_pkg::in_t                 in_data   = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	ceq_pkg::out_t                out_data;
	logic                         cfg_we    = 1'b0;
	logic [ceq_pkg::CFG_BITS-1:0] cfg_wdata = '0;

	coalescing_error_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// scoreboard state
	ceq_pkg::in_t  events_to_send[$];
	ceq_pkg::out_t reports_due[$];
	logic [15:0] code_pool[$];
	int n_errors      = 0;
	int idle_mode     = MODE_STEADY;
	int hold_requests = 0;

	// shadow copy of the error ring
	logic [15:0] rec_code[ceq_pkg::DEPTH];
	logic [31:0] rec_seq[ceq_pkg::DEPTH];
	logic [31:0] rec_reps[ceq_pkg::DEPTH];
	int          q_head      = 0;
	int          q_count     = 0;
	int          capacity    = ceq_pkg::DEPTH;
	logic [31:0] seq_next    = '0;
	logic [31:0] n_produced  = '0;
	logic [31:0] n_coalesced = '0;
	logic [31:0] n_dropped   = '0;
	logic [31:0] n_diag      = '0;
	logic        have_first  = 1'b0;
	logic [15:0] first_err   = '0;

	function automatic logic [31:0] bump32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic ceq_pkg::out_t next_report(input ceq_pkg::in_t ev);
		ceq_pkg::out_t r;
		int            k;
		int            s;
		logic          merged;
		logic [31:0]   taken_seq;
		r = '0;
		merged = 1'b0;
		if (ev.action == ceq_pkg::ACT_PUSH) begin
			taken_seq = seq_next;
			n_produced = bump32(n_produced);
			seq_next = bump32(seq_next);
			if (!have_first) begin
				have_first = 1'b1;
				first_err = ev.error_code;
			end
			for (k = 0; k < q_count; k++) begin
				s = (q_head + k) % capacity;
				if (!merged && rec_code[s] == ev.error_code) begin
					rec_reps[s] = bump32(rec_reps[s]);
					n_coalesced = bump32(n_coalesced);
					merged = 1'b1;
				end
			end
			if (!merged) begin
				if (q_count >= capacity) begin
					n_dropped = bump32(n_dropped);
				end else begin
					s = (q_head + q_count) % capacity;
					rec_code[s] = ev.error_code;
					rec_seq[s] = taken_seq;
					rec_reps[s] = 32'd1;
					q_count++;
				end
			end
		end else if (ev.action == ceq_pkg::ACT_POLL) begin
			if (q_count > 0) begin
				r.poll_valid = 1'b1;
				r.record_code = rec_code[q_head];
				r.record_sequence = rec_seq[q_head];
				r.record_repeats = rec_reps[q_head];
				q_head = (q_head + 1) % capacity;
				q_count--;
			end
		end else if (ev.action == ceq_pkg::ACT_DIAG) begin
			n_diag = bump32(n_diag);
		end
		r.occupancy = 5'(q_count);
		r.produced_total = n_produced;
		r.coalesced_total = n_coalesced;
		r.dropped_total = n_dropped;
		r.diagnostic_failures = n_diag;
		r.first_valid = have_first;
		r.first_code = first_err;
		return r;
	endfunction

	function automatic int src_idle_pct();
		return (idle_mode == MODE_SRC_IDLE) ? 86 : (idle_mode == MODE_BOTH) ? 17 : 0;
	endfunction

	function automatic int sink_stall_pct();
		return (idle_mode == MODE_SINK_STALL) ? 86 : (idle_mode == MODE_BOTH) ? 17 : 0;
	endfunction

	function automatic ceq_pkg::in_t make_event(input logic [1:0] act,
			input logic [15:0] code);
		ceq_pkg::in_t ev;
		ev.action = act;
		ev.error_code = code;
		return ev;
	endfunction

	// mostly pushes of pooled codes so records merge, fill up and drop
	function automatic ceq_pkg::in_t random_event();
		int          r;
		logic [1:0]  act;
		logic [15:0] code;
		r = $urandom_range(0, 99);
		if (r < 55)
			act = ceq_pkg::ACT_PUSH;
		else if (r < 82)
			act = ceq_pkg::ACT_POLL;
		else if (r < 94)
			act = ceq_pkg::ACT_DIAG;
		else
			act = ACT_UNKNOWN;
		if (act == ceq_pkg::ACT_PUSH && $urandom_range(0, 99) < 80)
			code = code_pool[$urandom_range(0, code_pool.size() - 1)];
		else
			code = 16'($urandom);
		return make_event(act, code);
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			n_errors++;
		end
	endtask

	// wait until every word went through and every report came back
	task automatic wait_drained();
		@(negedge clk);
		while (events_to_send.size() != 0 || in_valid || reports_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(input logic [ceq_pkg::CFG_BITS-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= ceq_pkg::CFG_BITS'($urandom);
		capacity = (v == 0) ? 1 : (v > ceq_pkg::DEPTH) ? ceq_pkg::DEPTH : int'(v);
		q_head = 0;
		q_count = 0;
		@(negedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				reports_due.push_back(next_report(in_data));
			if (!in_valid || in_ready) begin
				if (events_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct()) begin
					in_valid <= 1'b1;
					in_data <= events_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	int hold_served = 0;
	int hold_left   = 0;

	always @(posedge clk) begin : mon
		ceq_pkg::out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					$error("report word with nothing expected");
					n_errors++;
				end else begin
					want = reports_due.pop_front();
					check_field("poll_valid", want.poll_valid, out_data.poll_valid);
					check_field("record_code", want.record_code, out_data.record_code);
					check_field("record_sequence", want.record_sequence,
						out_data.record_sequence);
					check_field("record_repeats", want.record_repeats,
						out_data.record_repeats);
					check_field("occupancy", want.occupancy, out_data.occupancy);
					check_field("produced_total", want.produced_total,
						out_data.produced_total);
					check_field("coalesced_total", want.coalesced_total,
						out_data.coalesced_total);
					check_field("dropped_total", want.dropped_total, out_data.dropped_total);
					check_field("diagnostic_failures", want.diagnostic_failures,
						out_data.diagnostic_failures);
					check_field("first_valid", want.first_valid, out_data.first_valid);
					check_field("first_code", want.first_code, out_data.first_code);
				end
			end
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= sink_stall_pct());
			end
		end
	end

	// watchdog: too long without any word moving on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int caps[8];
		int ph;
		int k;
		caps = '{16, 3, 17, 8, 0, 12, 31, 5};
		caps[7] = $urandom_range(0, 31);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty poll, unknown action, first code, merge, drain past empty
		events_to_send.push_back(make_event(ceq_pkg::ACT_POLL, 16'h0000));
		events_to_send.push_back(make_event(ACT_UNKNOWN, 16'hFFFF));
		events_to_send.push_back(make_event(ceq_pkg::ACT_DIAG, 16'h0000));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'hFFFF));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'h0000));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'hFFFF));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'h5555));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'hAAAA));
		for (k = 0; k < 5; k++)
			events_to_send.push_back(make_event(ceq_pkg::ACT_POLL, 16'hFFFF));
		wait_drained();

		// capacity 0 clamps to one slot: merge, drop, leave a record behind
		write_capacity(5'd0);
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'h1234));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'h4321));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'h1234));
		events_to_send.push_back(make_event(ceq_pkg::ACT_POLL, 16'h0000));
		events_to_send.push_back(make_event(ceq_pkg::ACT_POLL, 16'h0000));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'h0F0F));
		wait_drained();

		// above depth clamps down; the write also flushes the leftover record
		write_capacity(5'd31);
		events_to_send.push_back(make_event(ceq_pkg::ACT_POLL, 16'h0000));
		events_to_send.push_back(make_event(ceq_pkg::ACT_PUSH, 16'h0F0F));
		events_to_send.push_back(make_event(ceq_pkg::ACT_POLL, 16'h0000));
		wait_drained();

		for (ph = 0; ph < 8; ph++) begin
			write_capacity(5'(caps[ph]));
			idle_mode = ph % 4;
			code_pool.delete();
			for (k = 0; k < capacity + 4; k++)
				code_pool.push_back(16'($urandom));
			if (ph == 4)
				hold_requests++;
			for (k = 0; k < 205; k++)
				events_to_send.push_back(random_event());
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
